[rtl/sldf_pkg.sv]
// ----------------------------------------------------------------------------
// sldf_pkg
// Shared constants, codes and types of the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package sldf_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 7;
  localparam int MIN_LEN     = 3;
  localparam int MAX_LEN     = MAX_PAYLOAD + 2;
  localparam int JOBQ_DEPTH  = 2;

  // ASCII "Frame", newest byte in the low bits
  localparam logic [39:0] SYNC_WORD = 40'h4672616D65;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_CSUM_BAD = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_LEN_BAD  = 2'd3
  } status_t;

  // One job for the back end: a status result or a forward run.
  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   flen;
  } job_t;

  // Back end to front end feedback.
  typedef struct packed {
    logic run_done;   // last store read of a forward run issued
  } back_stat_t;

endpackage

[rtl/sldf_ram.sv]
// ----------------------------------------------------------------------------
// sldf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sldf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sldf_front.sv]
// ----------------------------------------------------------------------------
// sldf_front
// Byte intake: sync hunt, length capture, payload store and checksum check.
// Pushes one job per finished frame or bad length.
// ----------------------------------------------------------------------------
module sldf_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  input  logic [7:0]                     report_code,
  output logic                           ram_we,
  output logic [sldf_pkg::PAY_AW-1:0]    ram_waddr,
  output logic [7:0]                     ram_wdata,
  output logic                           push,
  output sldf_pkg::job_t                 job,
  input  logic                           q_full,
  input  sldf_pkg::back_stat_t           back_stat
);

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_LEN_LO = 4'b0010,
    PH_LEN_HI = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  phase_t                       phase, phase_next;
  logic [39:0]                  window, window_next;
  logic [7:0]                   len_lo, len_lo_next;
  logic [sldf_pkg::LEN_W-1:0]   len, len_next;
  logic [sldf_pkg::LEN_W-1:0]   count, count_next;
  logic [7:0]                   sum, sum_next;
  logic [7:0]                   first, first_next;
  logic                         fwd_hold, fwd_hold_next;

  logic                         accept;
  logic [39:0]                  shifted;
  logic [15:0]                  len_full;
  logic [sldf_pkg::LEN_W-1:0]   count_inc;
  logic [sldf_pkg::LEN_W-1:0]   plen;
  logic [7:0]                   check;
  logic [7:0]                   first_now;

  assign in_stall = fwd_hold || q_full;
  assign accept   = in_valid && !in_stall;

  assign shifted   = {window[31:0], rx_byte};
  assign len_full  = {rx_byte, len_lo};
  assign count_inc = count + sldf_pkg::LEN_W'(1);
  assign plen      = len - sldf_pkg::LEN_W'(2);
  // valid lengths fit in the low byte, so the high length byte adds nothing
  assign check     = sum + {1'b0, len};
  assign first_now = (count == '0) ? rx_byte : first;

  always_comb begin
    phase_next    = phase;
    window_next   = window;
    len_lo_next   = len_lo;
    len_next      = len;
    count_next    = count;
    sum_next      = sum;
    first_next    = first;
    fwd_hold_next = fwd_hold;
    push          = 1'b0;
    job           = '0;
    ram_we        = 1'b0;
    ram_waddr     = count[sldf_pkg::PAY_AW-1:0];
    ram_wdata     = rx_byte;

    if (back_stat.run_done) begin
      fwd_hold_next = 1'b0;
    end

    unique case (phase)
      PH_HUNT: begin
        if (accept) begin
          if (shifted == sldf_pkg::SYNC_WORD) begin
            window_next = '0;
            phase_next  = PH_LEN_LO;
          end else begin
            window_next = shifted;
          end
        end
      end
      PH_LEN_LO: begin
        if (accept) begin
          len_lo_next = rx_byte;
          phase_next  = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        if (accept) begin
          if (len_full < 16'(sldf_pkg::MIN_LEN) || len_full > 16'(sldf_pkg::MAX_LEN)) begin
            push       = 1'b1;
            job.status = sldf_pkg::ST_LEN_BAD;
            job.flen   = '0;
            phase_next = PH_HUNT;
          end else begin
            len_next   = len_full[sldf_pkg::LEN_W-1:0];
            count_next = '0;
            sum_next   = '0;
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (accept) begin
          ram_we     = 1'b1;
          first_next = first_now;
          count_next = count_inc;
          if (count_inc < plen) begin
            sum_next = sum + rx_byte;
          end else begin
            push       = 1'b1;
            job.flen   = len;
            phase_next = PH_HUNT;
            count_next = '0;
            sum_next   = '0;
            if (check != rx_byte) begin
              job.status = sldf_pkg::ST_CSUM_BAD;
            end else if (first_now != report_code) begin
              job.status = sldf_pkg::ST_DROPPED;
            end else begin
              // store stays owned by the back end until its run is read out
              job.status    = sldf_pkg::ST_PAYLOAD;
              fwd_hold_next = 1'b1;
            end
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      window   <= '0;
      count    <= '0;
      sum      <= '0;
      fwd_hold <= 1'b0;
    end else begin
      phase    <= phase_next;
      window   <= window_next;
      count    <= count_next;
      sum      <= sum_next;
      fwd_hold <= fwd_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    len_lo <= len_lo_next;
    len    <= len_next;
    first  <= first_next;
  end

endmodule

[rtl/sldf_jobq.sv]
// ----------------------------------------------------------------------------
// sldf_jobq
// Short job queue between the intake and the result sequencer.
// ----------------------------------------------------------------------------
module sldf_jobq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sldf_pkg::job_t     push_job,
  input  logic               pop,
  output logic               q_valid,
  output logic               q_full,
  output sldf_pkg::job_t     head
);

  localparam int AW = (sldf_pkg::JOBQ_DEPTH > 1) ? $clog2(sldf_pkg::JOBQ_DEPTH) : 1;

  sldf_pkg::job_t   entries [sldf_pkg::JOBQ_DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      fill;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(sldf_pkg::JOBQ_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign q_valid = (fill != '0);
  assign q_full  = (fill == (AW+1)'(sldf_pkg::JOBQ_DEPTH));
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + (AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

[rtl/sldf_back.sv]
// ----------------------------------------------------------------------------
// sldf_back
// Result sequencer: turns jobs into status results or payload runs read
// back from the store, through one output register.
// ----------------------------------------------------------------------------
module sldf_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  sldf_pkg::job_t                 head,
  output logic                           pop,
  output logic                           ram_re,
  output logic [sldf_pkg::PAY_AW-1:0]    ram_raddr,
  input  logic [7:0]                     ram_rdata,
  output sldf_pkg::back_stat_t           back_stat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic [1:0]                     status,
  output logic                           last,
  output logic [sldf_pkg::LEN_W-1:0]     frame_length
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_t;

  bstate_t                      state, state_next;
  logic [sldf_pkg::LEN_W-1:0]   idx, plen, flen;
  logic                         rd_pend, rd_last;
  logic                         out_free;
  logic                         issue;
  logic                         issue_last;
  logic [sldf_pkg::LEN_W-1:0]   idx_inc;

  assign out_free   = !out_valid || !out_stall;
  assign idx_inc    = idx + sldf_pkg::LEN_W'(1);
  assign issue_last = (idx_inc == plen);
  assign ram_raddr  = idx[sldf_pkg::PAY_AW-1:0];

  always_comb begin
    state_next         = state;
    pop                = 1'b0;
    issue              = 1'b0;
    back_stat.run_done = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid && !rd_pend && out_free) begin
          pop = 1'b1;
          if (head.status == sldf_pkg::ST_PAYLOAD) begin
            state_next = B_RUN;
          end
        end
      end
      B_RUN: begin
        if (!rd_pend && out_free) begin
          issue = 1'b1;
          if (issue_last) begin
            state_next         = B_IDLE;
            back_stat.run_done = 1'b1;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  assign ram_re = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      // read data lands in the cycle after issue; output is free by then
      if (rd_pend || (pop && head.status != sldf_pkg::ST_PAYLOAD)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx  <= '0;
      flen <= head.flen;
      plen <= head.flen - sldf_pkg::LEN_W'(2);
    end else if (issue) begin
      idx <= idx_inc;
    end
    if (issue) begin
      rd_last <= issue_last;
    end
    if (rd_pend) begin
      out_byte     <= ram_rdata;
      status       <= sldf_pkg::ST_PAYLOAD;
      last         <= rd_last;
      frame_length <= flen;
    end else if (pop && head.status != sldf_pkg::ST_PAYLOAD) begin
      out_byte     <= '0;
      status       <= head.status;
      last         <= 1'b1;
      frame_length <= head.flen;
    end
  end

endmodule

[rtl/sync_length_checksum_deframer.sv]
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Sync-word framed receiver with length field and additive checksum.
// ----------------------------------------------------------------------------
// Bytes come in on rx_byte, one item per cycle while the block hunts for the
// ASCII sync word "Frame", reads the little-endian length and stores the
// payload. Each finished frame (or bad length) becomes a job in a two-entry
// queue; status results (checksum bad, not a report frame, bad length) leave
// as single items with out_byte zero and last set, and the intake keeps
// running unless the queue is full. A forwarded frame is replayed from the
// 64-byte payload RAM, one read at a time (registered RAM read, then the
// output register), and the intake stalls from the frame's last byte until
// the last read of the run has been issued, since the next frame writes the
// same RAM. report_code must be written through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [7:0]                     cfg_wr_data,
  // byte intake
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic [1:0]                     status,
  output logic                           last,
  output logic [sldf_pkg::LEN_W-1:0]     frame_length
);

  logic [7:0]                       report_code;

  // intake -> payload store
  logic                             ram_we;
  logic [sldf_pkg::PAY_AW-1:0]      ram_waddr;
  logic [7:0]                       ram_wdata;
  // sequencer -> payload store
  logic                             ram_re;
  logic [sldf_pkg::PAY_AW-1:0]      ram_raddr;
  logic [7:0]                       ram_rdata;

  // job queue
  logic                             push, pop, q_valid, q_full;
  sldf_pkg::job_t                   push_job, head;
  sldf_pkg::back_stat_t             back_stat;

  // the one config register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_code <= '0;
    end else if (cfg_wr_en) begin
      report_code <= cfg_wr_data;
    end
  end

  sldf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .report_code (report_code),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .push        (push),
    .job         (push_job),
    .q_full      (q_full),
    .back_stat   (back_stat)
  );

  sldf_ram #(
    .WIDTH (8),
    .DEPTH (sldf_pkg::MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sldf_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head)
  );

  sldf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .back_stat    (back_stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .status       (status),
    .last         (last),
    .frame_length (frame_length)
  );

`ifndef NO_ASSERTIONS
  // status results are always single-item runs with a zero data byte
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sldf_pkg::ST_PAYLOAD |-> last && out_byte == 8'd0)
    else $error("status result not a single zero item");

  // a bad length never reports a length
  a_badlen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sldf_pkg::ST_LEN_BAD |-> frame_length == '0)
    else $error("bad length result carries a length");

  // forwarded items always carry a length that passed the range check
  a_fwd_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sldf_pkg::ST_PAYLOAD |->
      frame_length >= sldf_pkg::LEN_W'(sldf_pkg::MIN_LEN) &&
      frame_length <= sldf_pkg::LEN_W'(sldf_pkg::MAX_LEN))
    else $error("forwarded item with out-of-range length");

  // the store is never written while a forward run still reads it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !ram_we)
    else $error("payload store written during readout");
`endif

endmodule
